### src/umb_pkg.sv
// Shared types and codes for the UART memory bridge.
// Holds the frame opcodes, result kinds, receive phases and the result struct.
// No dependencies.
`default_nettype none

package umb_pkg;

   // Top three bits of a link byte tag its role in a frame.
   localparam logic [2:0] OP_START   = 3'd4;
   localparam logic [2:0] OP_CHANNEL = 3'd5;
   localparam logic [2:0] OP_LENGTH  = 3'd6;
   localparam logic [2:0] OP_END     = 3'd7;

   // Result kinds.
   localparam logic [1:0] OUT_READ  = 2'd0;
   localparam logic [1:0] OUT_WRITE = 2'd1;
   localparam logic [1:0] OUT_TX    = 2'd2;

   // Payload sizes in bits that trigger a memory request.
   localparam logic [7:0] READ_BITS  = 8'd40;
   localparam logic [7:0] WRITE_BITS = 8'd72;

   // Length field of the reply frame.
   localparam logic [4:0] REPLY_LEN = 5'd4;

   // Number of link bytes in a reply frame, minus one.
   localparam logic [3:0] REPLY_LAST = 4'd8;

   typedef enum logic [2:0] {
      RX_IDLE,
      RX_CHANNEL,
      RX_LENGTH,
      RX_DATA,
      RX_END
   } rx_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] wdata;
      logic [3:0]  mask;
      logic [7:0]  tx_byte;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

### src/umb_deframe.sv
// Receive side of the UART memory bridge: frame parser and payload store.
// Produces at most one memory request per link byte; depends on umb_pkg.
`default_nettype none

module umb_deframe
   import umb_pkg::*;
#(
   parameter int STORE_BITS = 72
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output logic            res_valid,
   output result_type      res
);

   localparam int PAYLOAD_W = ((STORE_BITS + 7) / 8) * 8;
   localparam int IDX_W = $clog2(PAYLOAD_W);
   localparam logic [7:0] STORE_LIM = 8'(STORE_BITS);

   rx_phase_type           phase_ff, phase_in;
   logic [4:0]             id_ff, id_in;
   logic [7:0]             len_ff, len_in;
   logic [7:0]             cnt_ff, cnt_in;
   logic [PAYLOAD_W-1:0]   payload_ff, payload_in;
   logic [2:0]             op;
   logic [7:0]             remain;
   logic [7:0]             pos;

   assign op = rx_byte[7:5];
   assign remain = len_ff - cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RX_IDLE;
         id_ff <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         id_ff <= id_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         payload_ff <= payload_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      id_in = id_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      payload_in = payload_ff;
      pos = cnt_ff;
      res_valid = 1'b0;
      res = '0;
      res.last = 1'b1;
      case (phase_ff)
         RX_IDLE: begin
            if (op == OP_START) begin
               id_in = rx_byte[4:0];
               cnt_in = '0;
               len_in = '0;
               phase_in = RX_CHANNEL;
            end
         end
         RX_CHANNEL: begin
            phase_in = (op == OP_CHANNEL) ? RX_LENGTH : RX_IDLE;
         end
         RX_LENGTH: begin
            if (op == OP_LENGTH) begin
               len_in = {rx_byte[4:0], 3'b000};
               phase_in = RX_DATA;
            end else begin
               phase_in = RX_IDLE;
            end
         end
         RX_DATA: begin
            if (!rx_byte[7]) begin
               // Link bits arrive LSB first; bit p of the stream is stored at
               // the flat index p ^ 7 so that it lands MSB first in its byte.
               for (int i = 0; i < 7; i++) begin
                  pos = cnt_ff + 8'(i);
                  if (8'(i) < remain && pos < STORE_LIM) begin
                     payload_in[pos[IDX_W-1:0] ^ IDX_W'(7)] = rx_byte[i];
                  end
               end
               cnt_in = (remain > 8'd7) ? cnt_ff + 8'd7 : len_ff;
               if (cnt_in == len_ff) begin
                  phase_in = RX_END;
               end
            end else begin
               phase_in = RX_IDLE;
            end
         end
         RX_END: begin
            if (op == OP_END && rx_byte[4:0] == id_ff) begin
               if (cnt_ff == READ_BITS && payload_ff[39:32] == 8'd0) begin
                  res_valid = 1'b1;
                  res.kind = OUT_READ;
                  res.addr = {payload_ff[31:2], 2'b00};
               end else if (cnt_ff == WRITE_BITS) begin
                  res_valid = 1'b1;
                  res.kind = OUT_WRITE;
                  res.addr = {payload_ff[63:34], 2'b00};
                  res.wdata = payload_ff[31:0];
                  res.mask = payload_ff[67:64];
               end
            end
            phase_in = RX_IDLE;
         end
         default: begin
            phase_in = RX_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/umb_reply.sv
// Transmit side of the UART memory bridge: builds the nine-byte reply frame.
// Emits one link byte per emit pulse; depends on umb_pkg.
`default_nettype none

module umb_reply
   import umb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] read_data,
   input  wire logic        emit,
   output logic             busy,
   output result_type       res
);

   logic        busy_ff, busy_in;
   logic [3:0]  count_ff, count_in;
   logic [4:0]  id_ff, id_in;
   logic [31:0] data_ff;
   logic [7:0]  tx;

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
         id_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
         id_ff <= id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         data_ff <= read_data;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      count_in = count_ff;
      id_in = id_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = '0;
         id_in = id_ff + 5'd1;
      end else if (emit) begin
         if (count_ff == REPLY_LAST) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_comb begin
      case (count_ff)
         4'd0:    tx = {OP_START, id_ff};
         4'd1:    tx = {OP_CHANNEL, 5'd0};
         4'd2:    tx = {OP_LENGTH, REPLY_LEN};
         4'd3:    tx = {1'b0, data_ff[6:0]};
         4'd4:    tx = {1'b0, data_ff[13:7]};
         4'd5:    tx = {1'b0, data_ff[20:14]};
         4'd6:    tx = {1'b0, data_ff[27:21]};
         4'd7:    tx = {4'd0, data_ff[31:28]};
         4'd8:    tx = {OP_END, id_ff};
         default: tx = '0;
      endcase
      res = '0;
      res.kind = OUT_TX;
      res.tx_byte = tx;
      res.last = (count_ff == REPLY_LAST);
   end

endmodule

`default_nettype wire

### src/uart_memory_bridge.sv
// UART memory bridge top level: input register, frame parser, reply builder
// and result register. Depends on umb_pkg, umb_deframe and umb_reply.
//
// Each link byte item yields at most one memory read or write request, so
// byte items stream at one per cycle while not held by a reply or a stalled
// result. A returned read word with a read outstanding starts a reply of
// nine transmit byte items that the reply sequencer hands out one per cycle,
// unless stalled, through the single result register; the input register
// holds the following item until the last reply byte has gone. Read data
// with no read outstanding is dropped. The payload store is not cleared at
// reset; only bits written by the current frame are ever used.
`default_nettype none

module uart_memory_bridge
   import umb_pkg::*;
#(
   parameter int STORE_BITS = 72
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // rx_byte[7:0], read_data[39:8]
   input  wire logic        req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // mem_addr[31:0], mem_wdata[63:32],
                                         // byte_mask[67:64], tx_byte[75:68], zero
   output logic [1:0]       rsp_tuser,   // out_kind
   output logic             rsp_tlast    // last
);

   logic        in_valid_ff, in_valid_in;
   logic        in_kind_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_data_ff;
   logic        pending_ff, pending_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   logic        out_free;
   logic        advance;
   logic        byte_step;
   logic        read_step;
   logic        reply_busy;
   logic        reply_emit;
   logic        df_valid;
   result_type  df_res;
   result_type  reply_res;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance = in_valid_ff && !reply_busy && out_free;
   assign byte_step = advance && !in_kind_ff;
   assign read_step = advance && in_kind_ff && pending_ff;
   assign reply_emit = reply_busy && out_free;
   assign req_tready = !in_valid_ff || advance;

   umb_deframe #(
      .STORE_BITS(STORE_BITS)
   ) u_deframe (
      .clock(clock),
      .reset(reset),
      .step(byte_step),
      .rx_byte(in_byte_ff),
      .res_valid(df_valid),
      .res(df_res)
   );

   umb_reply u_reply (
      .clock(clock),
      .reset(reset),
      .start(read_step),
      .read_data(in_data_ff),
      .emit(reply_emit),
      .busy(reply_busy),
      .res(reply_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      pending_in = pending_ff;
      if (read_step) begin
         pending_in = 1'b0;
      end else if (byte_step && df_valid && df_res.kind == OUT_READ) begin
         pending_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = reply_emit || (byte_step && df_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
         in_data_ff <= req_tdata[39:8];
      end
      if (reply_emit) begin
         rsp_ff <= reply_res;
      end else if (out_free) begin
         rsp_ff <= df_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.kind;
   assign rsp_tlast = rsp_ff.last;
   assign rsp_tdata = {4'd0, rsp_ff.tx_byte, rsp_ff.mask, rsp_ff.wdata, rsp_ff.addr};

endmodule

`default_nettype wire

### src/umb_checker.sv
// Port-level checks for the UART memory bridge result channel.
// Depends on umb_pkg; bound to uart_memory_bridge at the end of this file.
`default_nettype none

module umb_checker
   import umb_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result item keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // Memory requests are single items with no transmit byte.
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != OUT_TX |-> rsp_tlast && rsp_tdata[75:68] == 8'd0)
      else $error("memory request is not a lone item");

   // Memory addresses are word aligned.
   a_req_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != OUT_TX |-> rsp_tdata[1:0] == 2'b00)
      else $error("memory address not word aligned");

   // The last byte of a reply frame is an end byte.
   a_reply_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OUT_TX && rsp_tlast |-> rsp_tdata[75:73] == OP_END)
      else $error("reply frame does not close with an end byte");

endmodule

bind uart_memory_bridge umb_checker u_umb_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

`default_nettype wire
